>>> rtl/core/aps_pkg.sv
// Shared types and constants of the aging priority task scheduler.
// Holds the task entry layout, status codes and field widths.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package aps_pkg;

   localparam int MAX_PROCESSES_DEF = 16;

   localparam int FUNC_W   = 1;
   localparam int SLOT_W   = 4;
   localparam int PRIO_W   = 16;
   localparam int TICK_W   = 16;
   localparam int LIMIT_W  = 8;
   localparam int STATUS_W = 2;
   localparam int PCOUNT_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_FINISHED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RUNNING  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_READY    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BLOCKED  = 2'd3;

   localparam logic signed [PRIO_W-1:0] PRIO_MAX   = 16'sh7FFF;
   localparam logic signed [PRIO_W-1:0] PRIO_MIN   = 16'sh8000;
   localparam logic signed [PRIO_W-1:0] PRIO_DROP  = 16'sd3;
   localparam logic signed [PRIO_W-1:0] PRIO_FLOOR = PRIO_MIN + PRIO_DROP;

   localparam logic [TICK_W-1:0]   TICK_MAX = '1;
   localparam logic [PCOUNT_W-1:0] DONE_MAX = '1;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [TICK_W-1:0]        cpu_ticks;
      logic [TICK_W-1:0]        remaining;
      logic [LIMIT_W-1:0]       run_limit;
      logic [LIMIT_W-1:0]       run_cd;
      logic [LIMIT_W-1:0]       block_limit;
      logic [LIMIT_W-1:0]       block_cd;
      logic [STATUS_W-1:0]      status;
   } entry_type;

   typedef struct packed {
      logic was_ready;
      logic release_cpu;
      logic finished;
   } alu_flags_type;

endpackage

`default_nettype wire

>>> rtl/core/aps_if.sv
// Valid/ready channel interfaces for the scheduler's request and response words.
// Depends on aps_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface aps_req_if;
   import aps_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [FUNC_W-1:0]          func;
   logic [SLOT_W-1:0]          slot;
   logic signed [PRIO_W-1:0]   init_priority;
   logic [TICK_W-1:0]          init_cpu_ticks;
   logic [TICK_W-1:0]          init_remaining;
   logic [LIMIT_W-1:0]         run_before_block;
   logic [LIMIT_W-1:0]         block_length;
   logic [STATUS_W-1:0]        init_status;

   modport source (
      output valid, func, slot, init_priority, init_cpu_ticks, init_remaining,
             run_before_block, block_length, init_status,
      input  ready
   );

   modport sink (
      input  valid, func, slot, init_priority, init_cpu_ticks, init_remaining,
             run_before_block, block_length, init_status,
      output ready
   );
endinterface

interface aps_rsp_if;
   import aps_pkg::*;

   logic                valid;
   logic                ready;
   logic                scheduled;
   logic [SLOT_W-1:0]   selected_slot;
   logic                cpu_busy;
   logic [PCOUNT_W-1:0] finished_count;
   logic                all_done;

   modport source (
      output valid, scheduled, selected_slot, cpu_busy, finished_count, all_done,
      input  ready
   );

   modport sink (
      input  valid, scheduled, selected_slot, cpu_busy, finished_count, all_done,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/aps_entry_mem.sv
// Task entry table: one write port and one registered read port.
// Depends on aps_pkg for the entry layout.
`timescale 1ns / 1ps
`default_nettype none

module aps_entry_mem #(
   parameter int DEPTH  = aps_pkg::MAX_PROCESSES_DEF,
   parameter int ADDR_W = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  aps_pkg::entry_type  wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output aps_pkg::entry_type  rd_data
);
   import aps_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/aps_entry_alu.sv
// Per-tick update of one task entry: aging, running accounting, block countdown.
// Depends on aps_pkg for the entry layout, status codes and saturation limits.
`timescale 1ns / 1ps
`default_nettype none

module aps_entry_alu (
   input  aps_pkg::entry_type     ent_i,
   output aps_pkg::entry_type     ent_o,
   output aps_pkg::alu_flags_type flags_o
);
   import aps_pkg::*;

   logic [TICK_W-1:0]  rem_dec;
   logic [LIMIT_W-1:0] run_cd_dec;
   logic [LIMIT_W-1:0] block_cd_dec;

   always_comb begin
      rem_dec      = (ent_i.remaining != '0) ? ent_i.remaining - 1'b1 : '0;
      run_cd_dec   = (ent_i.run_cd != '0) ? ent_i.run_cd - 1'b1 : '0;
      block_cd_dec = (ent_i.block_cd != '0) ? ent_i.block_cd - 1'b1 : '0;

      ent_o   = ent_i;
      flags_o = '0;

      case (ent_i.status)
         STAT_READY: begin
            flags_o.was_ready = 1'b1;
            if (ent_i.prio != PRIO_MAX) begin
               ent_o.prio = ent_i.prio + 16'sd1;
            end
         end
         STAT_RUNNING: begin
            ent_o.prio      = (ent_i.prio < PRIO_FLOOR) ? PRIO_MIN : ent_i.prio - PRIO_DROP;
            ent_o.cpu_ticks = (ent_i.cpu_ticks != TICK_MAX) ?
                              ent_i.cpu_ticks + 1'b1 : TICK_MAX;
            ent_o.remaining = rem_dec;
            ent_o.run_cd    = run_cd_dec;
            // Running out of work wins over the run length expiring.
            if (rem_dec == '0) begin
               ent_o.status        = STAT_FINISHED;
               flags_o.finished    = 1'b1;
               flags_o.release_cpu = 1'b1;
            end else if (run_cd_dec == '0 && ent_i.run_limit != '0) begin
               ent_o.status        = STAT_BLOCKED;
               ent_o.block_cd      = ent_i.block_limit;
               flags_o.release_cpu = 1'b1;
            end
         end
         STAT_BLOCKED: begin
            ent_o.block_cd = block_cd_dec;
            if (block_cd_dec == '0) begin
               ent_o.status = STAT_READY;
            end
         end
         default: begin
            ent_o = ent_i;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/aging_priority_task_scheduler_unit.sv
// Aging priority task scheduler: the sequencer, the busy and done state and the
// response register. Depends on aps_pkg, aps_if, aps_entry_mem and aps_entry_alu.
//
// A load word writes one task entry and goes straight to the response state. The
// next word can be accepted at the edge at which that response can first be taken.
// A tick word walks entries 0 .. n-1, n = min(process_count, MAX_PROCESSES),
// through one shared entry update unit, one entry per cycle behind the table's
// registered read port. It then starts the best ready entry if the CPU is not busy,
// and delivers its response. The request side is ready only between words; a
// response that is not yet taken holds the next word's response back but not its
// acceptance. The entry table has no reset: a tick must not walk an entry that was
// never loaded.
`timescale 1ns / 1ps
`default_nettype none

module aging_priority_task_scheduler_unit #(
   parameter int MAX_PROCESSES = aps_pkg::MAX_PROCESSES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   aps_req_if.sink                       req_chan,
   aps_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [aps_pkg::PCOUNT_W-1:0]  csr_wr_data
);
   import aps_pkg::*;

   localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
   localparam int CMP_W = (CNT_W > PCOUNT_W) ? CNT_W : PCOUNT_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PROCESSES);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [PCOUNT_W-1:0] pcount_ff, pcount_in;
   logic                busy_ff, busy_in;
   logic [PCOUNT_W-1:0] done_ff, done_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                vld_ff, vld_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                have_ff, have_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   entry_type           best_entry_ff, best_entry_in;
   logic                sched_ff, sched_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                rsp_sched_ff;
   logic [SLOT_W-1:0]   rsp_sel_ff;
   logic                rsp_busy_ff;
   logic [PCOUNT_W-1:0] rsp_fin_ff;
   logic                rsp_all_ff;
   logic                load_rsp;

   logic                req_fire;
   logic [CMP_W-1:0]    pcount_ext;
   logic [CMP_W-1:0]    walk_n;
   logic                issue_more;

   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   entry_type           mem_wr_data;
   logic [IDX_W-1:0]    mem_rd_addr;
   entry_type           mem_rd_data;
   entry_type           alu_out;
   alu_flags_type       alu_flags;
   entry_type           load_entry;

   aps_entry_mem #(
      .DEPTH  (MAX_PROCESSES),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   aps_entry_alu u_alu (
      .ent_i   (mem_rd_data),
      .ent_o   (alu_out),
      .flags_o (alu_flags)
   );

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign pcount_ext = CMP_W'(pcount_ff);
   assign walk_n     = (pcount_ext < MAX_CMP) ? pcount_ext : MAX_CMP;
   assign issue_more = CMP_W'(issue_ff) < walk_n;

   always_comb begin
      load_entry.prio        = req_chan.init_priority;
      load_entry.cpu_ticks   = req_chan.init_cpu_ticks;
      load_entry.remaining   = req_chan.init_remaining;
      load_entry.run_limit   = req_chan.run_before_block;
      load_entry.run_cd      = '0;
      load_entry.block_limit = req_chan.block_length;
      load_entry.block_cd    = '0;
      load_entry.status      = req_chan.init_status;
   end

   always_comb begin
      state_in      = state_ff;
      pcount_in     = csr_wr_en ? csr_wr_data : pcount_ff;
      busy_in       = busy_ff;
      done_in       = done_ff;
      issue_in      = issue_ff;
      vld_in        = vld_ff;
      idx_in        = idx_ff;
      have_in       = have_ff;
      best_idx_in   = best_idx_ff;
      best_entry_in = best_entry_ff;
      sched_in      = sched_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      load_rsp      = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = alu_out;
      mem_rd_addr   = issue_ff[IDX_W-1:0];
      req_chan.ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.func == FUNC_LOAD) begin
                  // Loads to a slot past the table are dropped.
                  mem_wr_en   = CMP_W'(req_chan.slot) < MAX_CMP;
                  mem_wr_addr = IDX_W'(req_chan.slot);
                  mem_wr_data = load_entry;
                  sched_in    = 1'b0;
                  state_in    = ST_RESP;
               end else begin
                  issue_in = '0;
                  vld_in   = 1'b0;
                  have_in  = 1'b0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            vld_in = issue_more;
            if (issue_more) begin
               idx_in   = issue_ff[IDX_W-1:0];
               issue_in = issue_ff + 1'b1;
            end
            if (vld_ff) begin
               mem_wr_en = 1'b1;
               if (alu_flags.release_cpu) begin
                  busy_in = 1'b0;
               end
               if (alu_flags.finished && done_ff != DONE_MAX) begin
                  done_in = done_ff + 1'b1;
               end
               // Ties go to the later slot, so an equal priority replaces the best.
               if (alu_flags.was_ready && (!have_ff || alu_out.prio >= best_entry_ff.prio)) begin
                  have_in       = 1'b1;
                  best_idx_in   = idx_ff;
                  best_entry_in = alu_out;
               end
            end
            if (!issue_more && !vld_ff) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            sched_in = 1'b0;
            if (!busy_ff && have_ff) begin
               mem_wr_en          = 1'b1;
               mem_wr_addr        = best_idx_ff;
               mem_wr_data        = best_entry_ff;
               mem_wr_data.status = STAT_RUNNING;
               mem_wr_data.run_cd = best_entry_ff.run_limit;
               busy_in            = 1'b1;
               sched_in           = 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               load_rsp     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcount_ff    <= PCOUNT_W'(1);
         busy_ff      <= 1'b0;
         done_ff      <= '0;
         issue_ff     <= '0;
         vld_ff       <= 1'b0;
         have_ff      <= 1'b0;
         sched_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         issue_ff     <= issue_in;
         vld_ff       <= vld_in;
         have_ff      <= have_in;
         sched_ff     <= sched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_entry_ff <= best_entry_in;
      if (load_rsp) begin
         rsp_sched_ff <= sched_ff;
         rsp_sel_ff   <= sched_ff ? SLOT_W'(best_idx_ff) : '0;
         rsp_busy_ff  <= busy_ff;
         rsp_fin_ff   <= done_ff;
         rsp_all_ff   <= (done_ff == pcount_ff);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.scheduled      = rsp_sched_ff;
   assign rsp_chan.selected_slot  = rsp_sel_ff;
   assign rsp_chan.cpu_busy       = rsp_busy_ff;
   assign rsp_chan.finished_count = rsp_fin_ff;
   assign rsp_chan.all_done       = rsp_all_ff;

   // A word that starts an entry must also report the CPU as busy.
   a_sched_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.scheduled) |-> rsp_chan.cpu_busy)
      else $error("scheduled response without busy CPU");

   // The walk writes back only entries inside the walked range.
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && mem_wr_en) |-> (CMP_W'(idx_ff) < walk_n))
      else $error("walk wrote past the entries in use");

   // A load goes straight to the response without walking the table.
   a_load_resp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.func == FUNC_LOAD) |=> (state_ff == ST_RESP))
      else $error("load word did not go to response");

   // The done count only moves during the walk.
   a_done_walk: assert property (@(posedge clock) disable iff (reset)
      (done_ff != $past(done_ff)) |-> ($past(state_ff) == ST_WALK))
      else $error("done count changed outside the walk");

endmodule

`default_nettype wire

>>> tb/aps_sched_tb_pkg.sv
`timescale 1ns / 1ps
// Request and response word types plus the task table tracker used by the scheduler bench.
// The tracker mirrors the entry table, busy flag and finish count to predict each response.
// Depends on aps_pkg for field widths, status codes and the entry layout.

package aps_sched_tb_pkg;
   import aps_pkg::*;

   typedef struct {
      logic [FUNC_W-1:0]        func;
      logic [SLOT_W-1:0]        slot;
      logic signed [PRIO_W-1:0] prio;
      logic [TICK_W-1:0]        cpu_ticks;
      logic [TICK_W-1:0]        remaining;
      logic [LIMIT_W-1:0]       run_len;
      logic [LIMIT_W-1:0]       block_len;
      logic [STATUS_W-1:0]      status;
   } sched_word_type;

   typedef struct {
      logic                scheduled;
      logic [SLOT_W-1:0]   slot;
      logic                busy;
      logic [PCOUNT_W-1:0] finished;
      logic                all_done;
   } sched_status_type;

   class task_table_tracker;
      entry_type           entries[MAX_PROCESSES_DEF];
      logic                busy;
      logic [PCOUNT_W-1:0] done_total;
      logic [PCOUNT_W-1:0] proc_count;
      sched_status_type    expected_status_q[$];
      int                  errors;
      int                  loads;
      int                  ticks;
      int                  starts;
      int                  finishes;
      int                  blocks;

      function new();
         foreach (entries[i]) entries[i] = '0;
         busy = 1'b0;
         done_total = '0;
         proc_count = 1;
         errors = 0;
         loads = 0;
         ticks = 0;
         starts = 0;
         finishes = 0;
         blocks = 0;
      endfunction

      function void set_count(logic [PCOUNT_W-1:0] value);
         proc_count = value;
      endfunction

      function int outstanding();
         return expected_status_q.size();
      endfunction

      // Applies one accepted word to the mirrored table and queues the response it implies.
      function void note_request(sched_word_type w);
         sched_status_type r;
         entry_type        e;
         int               n;
         int               p;
         int               best;
         int               best_prio;
         bit               have;
         r.scheduled = 1'b0;
         r.slot = '0;
         if (w.func == FUNC_LOAD) begin
            loads++;
            e.prio = w.prio;
            e.cpu_ticks = w.cpu_ticks;
            e.remaining = w.remaining;
            e.run_limit = w.run_len;
            e.run_cd = '0;
            e.block_limit = w.block_len;
            e.block_cd = '0;
            e.status = w.status;
            entries[w.slot] = e;
         end else begin
            ticks++;
            n = (proc_count < MAX_PROCESSES_DEF) ? int'(proc_count) : MAX_PROCESSES_DEF;
            have = 1'b0;
            best = 0;
            best_prio = 0;
            for (int i = 0; i < n; i++) begin
               e = entries[i];
               case (e.status)
                  STAT_READY: begin
                     if (e.prio != PRIO_MAX) e.prio = e.prio + 1;
                     p = $signed(e.prio);
                     // Later slots win ties, hence the greater-or-equal.
                     if (!have || p >= best_prio) begin
                        have = 1'b1;
                        best_prio = p;
                        best = i;
                     end
                  end
                  STAT_RUNNING: begin
                     p = $signed(e.prio);
                     p = (p < $signed(PRIO_FLOOR)) ? $signed(PRIO_MIN) : p - $signed(PRIO_DROP);
                     e.prio = p[PRIO_W-1:0];
                     if (e.cpu_ticks != TICK_MAX) e.cpu_ticks = e.cpu_ticks + 1;
                     if (e.remaining != 0) e.remaining = e.remaining - 1;
                     if (e.run_cd != 0) e.run_cd = e.run_cd - 1;
                     if (e.remaining == 0) begin
                        e.status = STAT_FINISHED;
                        busy = 1'b0;
                        if (done_total != DONE_MAX) done_total = done_total + 1;
                        finishes++;
                     end else if (e.run_cd == 0 && e.run_limit != 0) begin
                        e.status = STAT_BLOCKED;
                        e.block_cd = e.block_limit;
                        busy = 1'b0;
                        blocks++;
                     end
                  end
                  STAT_BLOCKED: begin
                     if (e.block_cd != 0) e.block_cd = e.block_cd - 1;
                     if (e.block_cd == 0) e.status = STAT_READY;
                  end
                  default: ;
               endcase
               entries[i] = e;
            end
            if (!busy && have) begin
               entries[best].status = STAT_RUNNING;
               entries[best].run_cd = entries[best].run_limit;
               busy = 1'b1;
               r.scheduled = 1'b1;
               r.slot = best[SLOT_W-1:0];
               starts++;
            end
         end
         r.busy = busy;
         r.finished = done_total;
         r.all_done = (done_total == proc_count);
         expected_status_q.push_back(r);
      endfunction

      function void check_response(sched_status_type got);
         sched_status_type exp;
         if (expected_status_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR %0t: response word with nothing expected", $realtime);
            return;
         end
         exp = expected_status_q.pop_front();
         if (got.scheduled !== exp.scheduled || got.slot !== exp.slot ||
             got.busy !== exp.busy || got.finished !== exp.finished ||
             got.all_done !== exp.all_done) begin
            errors++;
            if (errors <= 10)
               $display("ERROR %0t: sched/slot/busy/fin/all exp %b/%0d/%b/%0d/%b got %b/%0d/%b/%0d/%b",
                        $realtime, exp.scheduled, exp.slot, exp.busy, exp.finished, exp.all_done,
                        got.scheduled, got.slot, got.busy, got.finished, got.all_done);
         end
      endfunction
   endclass

endpackage

>>> tb/tb_aging_priority_task_scheduler_unit.sv
`timescale 1ns / 1ps
// Bench top for the aging priority task scheduler: clock, reset, request and response drivers.
// Runs a directed table setup, then random phases under varying process counts and stalls.
// Depends on aps_pkg, aps_if, aps_sched_tb_pkg and the scheduler RTL.

module tb_aging_priority_task_scheduler_unit;
   import aps_pkg::*;
   import aps_sched_tb_pkg::*;

   localparam int HOLD_CYCLES   = 200;
   localparam int STALL_LIMIT   = 1500;
   localparam int TOTAL_WORDS   = 500;
   localparam int SETTLE_CYCLES = 24;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [PCOUNT_W-1:0] csr_wr_data = '0;

   aps_req_if req_chan ();
   aps_rsp_if rsp_chan ();

   aging_priority_task_scheduler_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   task_table_tracker tracker = new();
   int idle_cycles = 0;
   int words_sent = 0;
   int rsp_seen = 0;
   int holds_done = 0;
   int count_settings = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   always #1 clock = ~clock;

   // Watchdog: any accepted word on either channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_aging_priority_task_scheduler_unit: done, errors");
            $finish;
         end
      end
   end

   function automatic sched_word_type load_word(int slot, int prio, int cpu, int rem,
                                                int run_len, int block_len,
                                                logic [STATUS_W-1:0] status);
      sched_word_type w;
      w.func = FUNC_LOAD;
      w.slot = slot[SLOT_W-1:0];
      w.prio = prio[PRIO_W-1:0];
      w.cpu_ticks = cpu[TICK_W-1:0];
      w.remaining = rem[TICK_W-1:0];
      w.run_len = run_len[LIMIT_W-1:0];
      w.block_len = block_len[LIMIT_W-1:0];
      w.status = status;
      return w;
   endfunction

   // The other fields of a tick word are don't-care, so they carry random bits.
   function automatic sched_word_type tick_word();
      sched_word_type w;
      w = load_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    STATUS_W'($urandom));
      w.func = FUNC_TICK;
      return w;
   endfunction

   task automatic send_word(input sched_word_type w);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.func = w.func;
      req_chan.slot = w.slot;
      req_chan.init_priority = w.prio;
      req_chan.init_cpu_ticks = w.cpu_ticks;
      req_chan.init_remaining = w.remaining;
      req_chan.run_before_block = w.run_len;
      req_chan.block_length = w.block_len;
      req_chan.init_status = w.status;
      req_chan.valid = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.note_request(w);
      words_sent++;
      req_burst = ((words_sent / 45) % 3) == 2;
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      req_chan.valid = 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
   endtask

   task automatic write_count(input logic [PCOUNT_W-1:0] value);
      wait_all_results();
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      tracker.set_count(value);
      count_settings++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Response side: random stalls, bursts with none, and two long hold-offs.
   initial begin
      sched_status_type got;
      int gap;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (holds_done < 2 && rsp_seen >= (holds_done == 0 ? 120 : 360) && req_chan.valid) begin
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         gap = rsp_burst ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         got.scheduled = rsp_chan.scheduled;
         got.slot = rsp_chan.selected_slot;
         got.busy = rsp_chan.cpu_busy;
         got.finished = rsp_chan.finished_count;
         got.all_done = rsp_chan.all_done;
         tracker.check_response(got);
         rsp_seen++;
         rsp_burst = ((rsp_seen / 37) % 3) == 1;
         @(negedge clock);
      end
   end

   initial begin
      sched_word_type      w;
      logic [PCOUNT_W-1:0] count;
      logic [STATUS_W-1:0] st;
      int                  span;
      int                  pick;
      int                  phase;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_LOAD;
      req_chan.slot = '0;
      req_chan.init_priority = '0;
      req_chan.init_cpu_ticks = '0;
      req_chan.init_remaining = '0;
      req_chan.run_before_block = '0;
      req_chan.block_length = '0;
      req_chan.init_status = STAT_FINISHED;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every slot is loaded before the first tick, so no tick reads an unwritten entry.
      // Slot 0 and 5 tie at the top priority; slot 1 runs with no work left; slot 2 runs
      // alongside whatever gets scheduled and saturates its CPU count.
      send_word(load_word(0, 32767, 0, 5, 0, 0, STAT_READY));
      send_word(load_word(1, -32768, 100, 0, 0, 0, STAT_RUNNING));
      send_word(load_word(2, -32767, 65535, 3, 2, 1, STAT_RUNNING));
      send_word(load_word(3, 0, 0, 10, 1, 255, STAT_READY));
      send_word(load_word(4, 100, 0, 4, 3, 2, STAT_BLOCKED));
      send_word(load_word(5, 32767, 1234, 65535, 255, 255, STAT_READY));
      send_word(load_word(6, -1, 0, 2, 1, 0, STAT_READY));
      send_word(load_word(7, 0, 0, 0, 0, 0, STAT_FINISHED));
      send_word(load_word(8, -32768, 0, 1, 0, 0, STAT_READY));
      send_word(load_word(9, 20, 0, 6, 2, 3, STAT_BLOCKED));
      for (int i = 10; i < MAX_PROCESSES_DEF; i++)
         send_word(load_word(i, i * 10 - 50, 0, i, i % 3, i % 4, STAT_READY));
      send_word(tick_word());
      write_count(16);
      repeat (6) send_word(tick_word());
      // A zero count walks nothing; a count above the table walks the whole table.
      write_count(0);
      send_word(tick_word());
      write_count(31);
      repeat (2) send_word(tick_word());

      phase = 0;
      while (words_sent < TOTAL_WORDS) begin
         if (phase == 0) begin
            count = 1;
         end else if (phase == 1) begin
            count = 16;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) count = 0;
            else if (pick == 1) count = PCOUNT_W'($urandom_range(17, 31));
            else count = PCOUNT_W'($urandom_range(1, 16));
         end
         write_count(count);
         span = (count == 0 || count > 16) ? 16 : int'(count);
         repeat ($urandom_range(15, 50)) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               w = tick_word();
            end else if (pick < 88) begin
               // Short, mostly ready tasks so they get scheduled, block and finish often.
               pick = $urandom_range(0, 9);
               st = (pick < 6) ? STAT_READY : (pick < 8) ? STAT_BLOCKED :
                    (pick == 8) ? STAT_RUNNING : STAT_FINISHED;
               w = load_word($urandom_range(0, span - 1), $urandom_range(0, 200) - 100,
                             $urandom_range(0, 65535), $urandom_range(1, 12),
                             $urandom_range(0, 4), $urandom_range(0, 5), st);
            end else begin
               w = load_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             STATUS_W'($urandom));
            end
            send_word(w);
         end
         phase++;
      end

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d words (%0d loads, %0d ticks) over %0d process count settings;",
               words_sent, tracker.loads, tracker.ticks, count_settings);
      $display("predicted %0d task starts, %0d finishes, %0d blocks, %0d long response holds.",
               tracker.starts, tracker.finishes, tracker.blocks, holds_done);
      if (tracker.errors == 0) begin
         $display("tb_aging_priority_task_scheduler_unit: done, clean");
      end else begin
         $display("tb_aging_priority_task_scheduler_unit: done, errors");
      end
      $finish;
   end

endmodule
